// ===== hw/rtl/ppc_pkg.sv =====
// Package for the polygon plane clipper: field widths, fixed-point formats,
// register indexes and the divider status type. No dependencies.
`default_nettype none

package ppc_pkg;

  // Field widths of the streamed items and of the configuration registers.
  localparam int unsigned CoordW   = 32;   // Q19.12 coordinates
  localparam int unsigned NormW    = 18;   // Q1.16 normal components
  localparam int unsigned CntW     = 9;    // output vertex count
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Fixed-point internals.
  localparam int unsigned FracW    = 16;             // fraction bits of t
  localparam int unsigned QW       = FracW + 1;      // t in Q1.16, so 1.0 fits
  localparam int unsigned DistW    = 53;             // exact Q.28 distance
  localparam int unsigned DenW     = DistW + 1;      // |dprev| + |dcur|
  localparam int unsigned MulAW    = CoordW + 1;     // coordinate difference
  localparam int unsigned MulBW    = NormW;          // normal or t
  localparam int unsigned ProdW    = MulAW + MulBW;  // full product

  localparam int unsigned MaxVerticesDef = 256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NORMAL_X   = 2'd0,
    CFG_NORMAL_Y   = 2'd1,
    CFG_NORMAL_Z   = 2'd2,
    CFG_PLANE_DIST = 2'd3
  } cfg_idx_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DistW-1:0]  dist_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppc_vertex_if.sv =====
// Vertex input channel of the polygon plane clipper: valid/ready handshake
// plus one vertex. Depends on ppc_pkg.
`default_nettype none

interface ppc_vertex_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppc_pkg::CoordW-1:0]   vertex_x;
  logic signed [ppc_pkg::CoordW-1:0]   vertex_y;
  logic signed [ppc_pkg::CoordW-1:0]   vertex_z;
  logic                                last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ppc_result_if.sv =====
// Result output channel of the polygon plane clipper: valid/ready handshake
// plus one clipped vertex or terminator. Depends on ppc_pkg.
`default_nettype none

interface ppc_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppc_pkg::CoordW-1:0]   out_x;
  logic signed [ppc_pkg::CoordW-1:0]   out_y;
  logic signed [ppc_pkg::CoordW-1:0]   out_z;
  logic                                is_end;
  logic [ppc_pkg::CntW-1:0]            out_count;

  modport source (output valid, out_x, out_y, out_z, is_end, out_count, input ready);
  modport sink   (input valid, out_x, out_y, out_z, is_end, out_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ppc_mac.sv =====
// Shared signed multiplier of the polygon plane clipper with a registered
// product. Depends on ppc_pkg.
`default_nettype none

module ppc_mac (
  input  logic                               clk_i,
  input  logic signed [ppc_pkg::MulAW-1:0]   a_i,
  input  logic signed [ppc_pkg::MulBW-1:0]   b_i,
  output logic signed [ppc_pkg::ProdW-1:0]   prod_o
);
  import ppc_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ppc_div.sv =====
// Iterative restoring divider of the polygon plane clipper: one quotient bit
// per cycle, giving t = num / den in Q1.16. Depends on ppc_pkg.
`default_nettype none

module ppc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ppc_pkg::DistW-1:0]     num_i,
  input  logic [ppc_pkg::DenW-1:0]      den_i,
  output ppc_pkg::div_status_t          status_o,
  output logic [ppc_pkg::QW-1:0]        quot_o
);
  import ppc_pkg::*;

  localparam int unsigned StepW = $clog2(FracW + 1);
  localparam logic [StepW-1:0] LastStep = StepW'(FracW);

  logic [DenW-1:0]  rem_q;
  logic [DenW-1:0]  den_q;
  logic [QW-1:0]    quot_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;

  // The first step decides the integer bit without shifting; every later
  // step shifts the remainder left by one.
  logic [DenW:0] trial;
  logic          fits;

  assign trial = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      quot_q <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
      step_q <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q  <= fits ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
      quot_q <= {quot_q[QW-2:0], fits};
      step_q <= step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/polygon_plane_clipper_top.sv =====
// Top level of the polygon plane clipper: sequencer, vertex and plane state,
// output register. Depends on ppc_pkg, ppc_vertex_if, ppc_result_if,
// ppc_mac and ppc_div.
`default_nettype none

// Sutherland-Hodgman clipping of one polygon against one plane. Vertices
// arrive one transaction at a time on vertex_i; the last one is flagged by
// last_vertex. Each vertex gets the exact signed distance n . v - plane_dist
// (Q.28), and a distance of zero or more counts as in front. For each edge
// the block emits the start vertex when it is in front, and a split point when
// the edge crosses the plane, at t = dprev / (dprev - dcur) in Q1.16 with
// round-to-nearest interpolation. The last vertex also closes the polygon with
// the edge back to the first vertex, after which a terminator transaction
// (is_end = 1, zero coordinates) carries the number of emitted vertices,
// saturating at 2*MAX_VERTICES-1. The output is therefore the usual cyclic
// order, rotated to start with the edge from the first to the second vertex.
// The block handles one vertex at a time and drops ready while it works. A
// vertex goes through acceptance and distance computation, then the edge step
// for each edge it runs, the divider and interpolation for every edge that
// crosses the plane, and for a closing vertex the terminator. The crossings
// dominate: each runs the 17-step iterative divider and then three passes
// through the single shared multiplier, which also computes the three products
// of each distance. A finished result sits in an output register, so a stalled
// sink only holds the sequencer when the next result is ready to go.
// Configuration writes on the cfg port are meant to happen while the block is
// idle.
module polygon_plane_clipper_top #(
  parameter int unsigned MAX_VERTICES = ppc_pkg::MaxVerticesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ppc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ppc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  ppc_vertex_if.sink                     vertex_i,
  ppc_result_if.source                   result_o
);
  import ppc_pkg::*;

  localparam logic [CntW-1:0] CountSat = CntW'(2 * MAX_VERTICES - 1);
  localparam logic [QW-1:0]   QOne     = QW'(2 ** FracW);
  localparam logic [ProdW-1:0] RoundHalf = ProdW'(2 ** (FracW - 1));
  localparam int unsigned     LerpW    = CoordW + 2;

  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for a vertex
    ST_DIST,   // three products of the distance, accumulated
    ST_POST,   // first vertex bookkeeping, choose the edges to run
    ST_EDGE,   // emit the start vertex, decide on a crossing
    ST_DIV,    // divider computes t
    ST_LERP,   // three interpolations through the multiplier
    ST_EMIT,   // emit the split point
    ST_NEXT,   // advance to the closing edge or finish
    ST_TERM    // emit the terminator
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [NormW-1:0] normal_q [3];
  coord_t                  plane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q[0] <= '0;
      normal_q[1] <= '0;
      normal_q[2] <= NormW'(2 ** FracW);
      plane_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NORMAL_X:   normal_q[0] <= cfg_wdata_i[NormW-1:0];
        CFG_NORMAL_Y:   normal_q[1] <= cfg_wdata_i[NormW-1:0];
        CFG_NORMAL_Z:   normal_q[2] <= cfg_wdata_i[NormW-1:0];
        CFG_PLANE_DIST: plane_q     <= cfg_wdata_i[CoordW-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and vertex storage
  // ---------------------------------------------------------------------------
  state_e        state_q;
  logic [1:0]    cnt_q;       // step within the distance and interpolation passes
  logic          edge_q;      // 0: edge from previous vertex, 1: closing edge
  logic          last_q;
  logic          in_poly_q;
  logic [CntW-1:0] count_q;
  logic          div_start_q;

  coord_t        cur_q   [3];
  coord_t        first_q [3];
  coord_t        prev_q  [3];
  coord_t        split_q [3];
  dist_t         dist_q;
  dist_t         fdist_q;
  dist_t         pdist_q;

  logic          out_v_q;
  coord_t        out_x_q;
  coord_t        out_y_q;
  coord_t        out_z_q;
  logic          out_end_q;
  logic [CntW-1:0] out_cnt_q;

  // ---------------------------------------------------------------------------
  // Edge operands: the start vertex is always the previous vertex, since it
  // is updated to the current vertex before the closing edge runs.
  // ---------------------------------------------------------------------------
  coord_t        c_v [3];
  dist_t         c_d;
  logic          a_front;
  logic          c_front;
  logic [DistW-1:0] a_mag;
  logic [DistW-1:0] c_mag;
  logic [DenW-1:0]  den;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_v[i] = edge_q ? first_q[i] : cur_q[i];
    end
  end

  assign c_d     = edge_q ? fdist_q : dist_q;
  assign a_front = !pdist_q[DistW-1];
  assign c_front = !c_d[DistW-1];
  assign a_mag   = a_front ? DistW'(pdist_q) : DistW'(-pdist_q);
  assign c_mag   = c_front ? DistW'(c_d) : DistW'(-c_d);
  assign den     = {1'b0, a_mag} + {1'b0, c_mag};

  // ---------------------------------------------------------------------------
  // Shared multiplier and divider
  // ---------------------------------------------------------------------------
  logic [1:0]              mul_idx;
  logic [1:0]              acc_idx;
  logic signed [MulAW-1:0] mac_a;
  logic signed [MulBW-1:0] mac_b;
  logic signed [ProdW-1:0] prod;
  div_status_t             div_st;
  logic [QW-1:0]           quot;

  assign mul_idx = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
  assign acc_idx = cnt_q - 2'd1;

  always_comb begin
    if (state_q == ST_LERP) begin
      mac_a = {c_v[mul_idx][CoordW-1], c_v[mul_idx]}
            - {prev_q[mul_idx][CoordW-1], prev_q[mul_idx]};
      mac_b = $signed({1'b0, quot});
    end else begin
      mac_a = {cur_q[mul_idx][CoordW-1], cur_q[mul_idx]};
      mac_b = normal_q[mul_idx];
    end
  end

  ppc_mac u_mac (
    .clk_i  (clk_i),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .prod_o (prod)
  );

  ppc_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start_q),
    .num_i    (a_mag),
    .den_i    (den),
    .status_o (div_st),
    .quot_o   (quot)
  );

  // Distance accumulation and the rounded interpolation step.
  dist_t                prod_ext;
  dist_t                plane_ext;
  logic [ProdW-1:0]     prod_mag;
  logic [ProdW-1:0]     rnd_full;
  logic signed [LerpW-1:0] delta;
  logic signed [LerpW-1:0] split_sum;

  assign prod_ext  = {{(DistW - ProdW){prod[ProdW-1]}}, prod};
  assign plane_ext = {{(DistW - CoordW - FracW){plane_q[CoordW-1]}}, plane_q, {FracW{1'b0}}};
  assign prod_mag  = prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
  assign rnd_full  = (prod_mag + RoundHalf) >> FracW;
  assign delta     = prod[ProdW-1] ? -$signed({1'b0, rnd_full[CoordW:0]})
                                   :  $signed({1'b0, rnd_full[CoordW:0]});
  assign split_sum = {{2{prev_q[acc_idx][CoordW-1]}}, prev_q[acc_idx]} + delta;

  logic out_free;
  assign out_free = !out_v_q || result_o.ready;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      edge_q      <= 1'b0;
      last_q      <= 1'b0;
      in_poly_q   <= 1'b0;
      count_q     <= '0;
      div_start_q <= 1'b0;
      cur_q       <= '{default: '0};
      first_q     <= '{default: '0};
      prev_q      <= '{default: '0};
      split_q     <= '{default: '0};
      dist_q      <= '0;
      fdist_q     <= '0;
      pdist_q     <= '0;
      out_v_q     <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_z_q     <= '0;
      out_end_q   <= 1'b0;
      out_cnt_q   <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (result_o.ready) begin
        out_v_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (vertex_i.valid) begin
            cur_q[0] <= vertex_i.vertex_x;
            cur_q[1] <= vertex_i.vertex_y;
            cur_q[2] <= vertex_i.vertex_z;
            last_q   <= vertex_i.last_vertex;
            cnt_q    <= '0;
            state_q  <= ST_DIST;
          end
        end

        ST_DIST: begin
          // Product k is issued at step k and added at the next step, from the registered product.
          if (cnt_q == 2'd0) begin
            dist_q <= -plane_ext;
          end else begin
            dist_q <= dist_q + prod_ext;
          end
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= ST_POST;
          end
        end

        ST_POST: begin
          if (!in_poly_q) begin
            // Opening vertex: it becomes both first and previous vertex.
            first_q   <= cur_q;
            prev_q    <= cur_q;
            fdist_q   <= dist_q;
            pdist_q   <= dist_q;
            count_q   <= '0;
            in_poly_q <= 1'b1;
            edge_q    <= 1'b1;
            state_q   <= last_q ? ST_EDGE : ST_IDLE;
          end else begin
            edge_q  <= 1'b0;
            state_q <= ST_EDGE;
          end
        end

        ST_EDGE: begin
          if (!a_front || out_free) begin
            if (a_front) begin
              out_v_q   <= 1'b1;
              out_x_q   <= prev_q[0];
              out_y_q   <= prev_q[1];
              out_z_q   <= prev_q[2];
              out_end_q <= 1'b0;
              out_cnt_q <= '0;
              if (count_q < CountSat) begin
                count_q <= count_q + 1'b1;
              end
            end
            if (a_front != c_front) begin
              div_start_q <= 1'b1;
              state_q     <= ST_DIV;
            end else begin
              state_q <= ST_NEXT;
            end
          end
        end

        ST_DIV: begin
          // The done flag of the previous division is still visible while
          // the start pulse is in flight.
          if (div_st.done && !div_start_q) begin
            cnt_q   <= '0;
            state_q <= ST_LERP;
          end
        end

        ST_LERP: begin
          if (cnt_q != 2'd0) begin
            split_q[acc_idx] <= split_sum[CoordW-1:0];
          end
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_v_q   <= 1'b1;
            out_x_q   <= split_q[0];
            out_y_q   <= split_q[1];
            out_z_q   <= split_q[2];
            out_end_q <= 1'b0;
            out_cnt_q <= '0;
            if (count_q < CountSat) begin
              count_q <= count_q + 1'b1;
            end
            state_q <= ST_NEXT;
          end
        end

        ST_NEXT: begin
          if (!edge_q) begin
            prev_q  <= cur_q;
            pdist_q <= dist_q;
            if (last_q) begin
              edge_q  <= 1'b1;
              state_q <= ST_EDGE;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            state_q <= ST_TERM;
          end
        end

        ST_TERM: begin
          if (out_free) begin
            out_v_q   <= 1'b1;
            out_x_q   <= '0;
            out_y_q   <= '0;
            out_z_q   <= '0;
            out_end_q <= 1'b1;
            out_cnt_q <= count_q;
            in_poly_q <= 1'b0;
            count_q   <= '0;
            state_q   <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign vertex_i.ready     = (state_q == ST_IDLE);
  assign result_o.valid     = out_v_q;
  assign result_o.out_x     = out_x_q;
  assign result_o.out_y     = out_y_q;
  assign result_o.out_z     = out_z_q;
  assign result_o.is_end    = out_end_q;
  assign result_o.out_count = out_cnt_q;

`ifndef SYNTHESIS
  // The divider only runs while a vertex is being processed.
  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vertex_i.ready |-> !div_st.busy)
    else $error("divider busy while the clipper is idle");

  // Both edge endpoints lie on opposite sides, so t never exceeds 1.0.
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> quot <= QOne)
    else $error("interpolation factor above one");

  // The emitted vertex count saturates.
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountSat)
    else $error("vertex count beyond saturation value");

  // An accepted vertex always starts the distance pass.
  a_accept_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vertex_i.valid && vertex_i.ready) |=> (state_q == ST_DIST && cnt_q == 2'd0))
    else $error("accepted vertex did not start the distance pass");
`endif

endmodule

`default_nettype wire

// ===== tb/polygon_plane_clipper_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for polygon_plane_clipper_top: streams directed and random polygons,
// predicts every clipped vertex and terminator, and compares them with the block's results.
// Depends on ppc_pkg, ppc_vertex_if, ppc_result_if and the clipper RTL.
module polygon_plane_clipper_top_test;
  import ppc_pkg::*;

  // The vertex count on the terminator saturates at this value.
  localparam int unsigned COUNT_LIMIT   = 2 * MaxVerticesDef - 1;
  // Long enough for any vertex that is still in flight without producing a
  // result to finish, including a closing vertex with two crossings.
  localparam int unsigned SETTLE_CYCLES = 100;
  // Length of the deliberate long stall on the result side.
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS  = 60;
  localparam int unsigned RANDOM_PHASES = 3;
  // Alternating front/back vertices emit 1.5 results per vertex on average,
  // so this many vertices pushes the emitted count just past the limit.
  localparam int unsigned SAT_VERTICES  = 344;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef coord_t vec3_t [3];

  // One clipped vertex or terminator as it appears on the result channel.
  typedef struct packed {
    coord_t          x;
    coord_t          y;
    coord_t          z;
    logic            is_end;
    logic [CntW-1:0] count;
  } clip_out_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  ppc_vertex_if vertex_ch ();
  ppc_result_if result_ch ();

  polygon_plane_clipper_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .vertex_i    (vertex_ch),
    .result_o    (result_ch)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the plane registers, starting from their reset values.
  logic signed [NormW-1:0] plane_nx = '0;
  logic signed [NormW-1:0] plane_ny = '0;
  logic signed [NormW-1:0] plane_nz = 18'sh10000;
  coord_t                  plane_d  = '0;

  // Shadow copy of the polygon state: first and previous vertex with their
  // exact distances, whether a polygon is open, and the emitted count.
  vec3_t       first_v = '{default: '0};
  vec3_t       prev_v  = '{default: '0};
  longint      first_d = 0;
  longint      prev_d  = 0;
  bit          poly_open = 1'b0;
  int unsigned emitted_n = 0;

  // Predicted results in the order the block must deliver them.
  clip_out_t   pending_clip_q [$];
  int unsigned mismatch_n = 0;
  int unsigned random_items_sent = 0;

  // Idle controls for the vertex and result channels, set by the stimulus.
  bit src_idle_on   = 1'b1;
  bit sink_idle_on  = 1'b1;
  bit sink_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Exact signed distance n . v - plane_dist in Q.28; the sum fits in 51 bits.
  function automatic longint plane_distance(vec3_t v);
    return longint'(plane_nx) * longint'(v[0]) + longint'(plane_ny) * longint'(v[1])
         + longint'(plane_nz) * longint'(v[2]) - longint'(plane_d) * 64'sd65536;
  endfunction

  function automatic void emit_vertex(vec3_t v);
    pending_clip_q.push_back('{x: v[0], y: v[1], z: v[2], is_end: 1'b0, count: '0});
    if (emitted_n < COUNT_LIMIT) emitted_n++;
  endfunction

  // One Sutherland-Hodgman edge step: the start vertex when it is in front,
  // then the split point when the edge changes side.
  function automatic void clip_edge(vec3_t pv, longint pdist, vec3_t cv, longint cdist);
    bit           p_front, c_front;
    longint       p_mag, c_mag, t_q, prod, rnd;
    logic [127:0] num, den, quot;
    vec3_t        split;
    p_front = (pdist >= 0);
    c_front = (cdist >= 0);
    if (p_front) emit_vertex(pv);
    if (p_front == c_front) return;
    p_mag = (pdist < 0) ? -pdist : pdist;
    c_mag = (cdist < 0) ? -cdist : cdist;
    num   = {64'd0, p_mag};
    den   = num + {64'd0, c_mag};
    // t = floor(|dprev| * 2^16 / (|dprev| + |dcur|)), which can reach 1.0 exactly.
    quot  = (num << 16) / den;
    t_q   = quot[63:0];
    for (int i = 0; i < 3; i++) begin
      prod = (longint'(cv[i]) - longint'(pv[i])) * t_q;
      // Round half away from zero on the magnitude, then restore the sign.
      rnd  = ((prod < 0 ? -prod : prod) + 64'sd32768) >>> 16;
      split[i] = coord_t'(longint'(pv[i]) + (prod < 0 ? -rnd : rnd));
    end
    emit_vertex(split);
  endfunction

  // Advances the shadow state by one accepted vertex and queues its results.
  function automatic void predict_clip(coord_t x, coord_t y, coord_t z, logic last);
    vec3_t  v;
    longint d;
    v = '{x, y, z};
    d = plane_distance(v);
    if (!poly_open) begin
      first_v   = v;
      first_d   = d;
      emitted_n = 0;
      poly_open = 1'b1;
    end else begin
      clip_edge(prev_v, prev_d, v, d);
    end
    prev_v = v;
    prev_d = d;
    if (last) begin
      // The wrap-around edge closes the polygon; a single vertex closes on itself.
      clip_edge(v, d, first_v, first_d);
      pending_clip_q.push_back('{x: '0, y: '0, z: '0, is_end: 1'b1,
                                 count: emitted_n[CntW-1:0]});
      poly_open = 1'b0;
      emitted_n = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Most gaps are zero or short, a few are long.
  function automatic int unsigned idle_len(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Coordinates are mostly within +/-1024 units so that planes cut the
  // polygons often; wide_pct percent of them use the full 32-bit range.
  function automatic coord_t rand_coord(int unsigned wide_pct);
    coord_t c;
    c = $urandom;
    if ($urandom_range(99) >= wide_pct) c = c >>> 9;
    return c;
  endfunction

  // Normal components: the in-range extremes, zero, any 18-bit pattern (upper
  // write data bits random as well), or a random in-range value.
  function automatic logic [CfgDataW-1:0] rand_normal();
    int v;
    case ($urandom_range(5))
      0:       v = 65536;
      1:       v = -65536;
      2:       v = 0;
      3:       v = $urandom;
      default: v = int'($urandom_range(131072)) - 65536;
    endcase
    return v;
  endfunction

  function automatic logic [CfgDataW-1:0] rand_plane_dist();
    logic [CfgDataW-1:0] v;
    case ($urandom_range(3))
      0:       v = $urandom;
      1:       v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel and register access
  // ---------------------------------------------------------------------------

  // Writes one plane register and mirrors it in the shadow copy. The enable is
  // lowered on the following edge, so back-to-back writes never collide.
  task automatic write_plane_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_NORMAL_X:   plane_nx = data[NormW-1:0];
      CFG_NORMAL_Y:   plane_ny = data[NormW-1:0];
      CFG_NORMAL_Z:   plane_nz = data[NormW-1:0];
      CFG_PLANE_DIST: plane_d  = data;
      default:        ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_plane(input logic [CfgDataW-1:0] nx, ny, nz, dist_val);
    write_plane_reg(CFG_NORMAL_X, nx);
    write_plane_reg(CFG_NORMAL_Y, ny);
    write_plane_reg(CFG_NORMAL_Z, nz);
    write_plane_reg(CFG_PLANE_DIST, dist_val);
  endtask

  // Offers one vertex and returns at the edge where the transaction completes.
  // Valid stays high on return so that a following vertex can go back to back.
  task automatic send_vertex(input coord_t x, y, z, input logic last);
    int unsigned gap;
    gap = idle_len(src_idle_on);
    if (gap != 0) begin
      vertex_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    vertex_ch.valid       <= 1'b1;
    vertex_ch.vertex_x    <= x;
    vertex_ch.vertex_y    <= y;
    vertex_ch.vertex_z    <= z;
    vertex_ch.last_vertex <= last;
    do @(posedge clk_i); while (!vertex_ch.ready);
    predict_clip(x, y, z, last);
  endtask

  // Stops offering vertices until every predicted result has arrived, then
  // lets a vertex that produces no result finish before anything else happens.
  task automatic wait_for_results();
    vertex_ch.valid <= 1'b0;
    while (pending_clip_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_polygon(input int unsigned n, input int unsigned wide_pct);
    for (int unsigned i = 0; i < n; i++) begin
      send_vertex(rand_coord(wide_pct), rand_coord(wide_pct), rand_coord(wide_pct),
                  i == n - 1);
    end
  endtask

  // Vertices alternate in front of and behind the plane z = 0, so every edge
  // crosses it when n is even. Only meaningful with the plane set to that orientation.
  task automatic send_alternating_polygon(input int unsigned n);
    coord_t z;
    for (int unsigned i = 0; i < n; i++) begin
      z = coord_t'($urandom_range(32'h0040_0000, 1));
      if (i % 2 == 1) z = -z;
      send_vertex(rand_coord(0), rand_coord(0), z, i == n - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Uses the reset plane z = 0. The polygon has a vertex exactly on the plane,
  // so one split lands at t = 1.0 (the on-plane vertex) and one at t = 0.
  task automatic test_reset_plane();
    send_vertex(0, 0, 4096, 1'b0);
    send_vertex(4096, 0, -4096, 1'b0);
    send_vertex(0, 4096, 0, 1'b0);
    send_vertex(8192, 12288, -12288, 1'b1);
    wait_for_results();
  endtask

  // A polygon of one vertex closes on itself: in front it is emitted once,
  // behind the plane only the terminator with a zero count comes out.
  task automatic test_single_vertex();
    send_vertex(100, -200, 4096, 1'b1);
    send_vertex(5, 6, -1, 1'b1);
    wait_for_results();
  endtask

  // Extreme coordinates against extreme planes, including 18-bit patterns
  // outside the nominal normal range and a plane with a zero normal.
  task automatic test_coordinate_extremes();
    coord_t c_max, c_min;
    c_max = 32'sh7FFF_FFFF;
    c_min = 32'sh8000_0000;
    set_plane(32'sd65536, -32'sd65536, 32'sd65536, 32'h8000_0000);
    send_vertex(c_max, c_min, c_max, 1'b0);
    send_vertex(c_min, c_max, c_min, 1'b0);
    send_vertex(c_max, c_max, c_min, 1'b0);
    send_vertex(c_min, c_min, c_max, 1'b1);
    wait_for_results();
    set_plane(32'h0001_FFFF, 32'h0002_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(c_min, c_max, c_max, 1'b0);
    send_vertex(c_max, c_min, c_min, 1'b0);
    send_vertex(c_min, c_min, c_min, 1'b0);
    send_vertex(c_max, c_max, c_max, 1'b1);
    wait_for_results();
    // Every distance is zero here, which counts as in front: nothing is cut.
    set_plane('0, '0, '0, '0);
    send_vertex(0, 0, 0, 1'b0);
    send_vertex(c_max, c_min, 4096, 1'b0);
    send_vertex(c_min, c_max, -4096, 1'b1);
    wait_for_results();
  endtask

  // Random polygons over several plane settings. Phase two runs with no
  // idling on either channel; the others idle at random.
  task automatic test_random_polygons();
    int unsigned n, r;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      src_idle_on  = (phase != 2);
      sink_idle_on = (phase != 2);
      set_plane(rand_normal(), rand_normal(), rand_normal(), rand_plane_dist());
      while (random_items_sent < (phase + 1) * RANDOM_ITEMS / RANDOM_PHASES) begin
        r = $urandom_range(99);
        if (r < 5)       n = 1;
        else if (r < 10) n = 2;
        else if (r < 90) n = $urandom_range(8, 3);
        else             n = $urandom_range(20, 9);
        send_random_polygon(n, 10);
        random_items_sent += n;
      end
      wait_for_results();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // The result side holds off for a long stretch while vertices keep coming,
  // so the output register fills and the block stops accepting vertices.
  // Afterwards the sender waits until every result has been delivered.
  task automatic test_output_stall();
    set_plane('0, '0, 32'sd65536, '0);
    sink_hold_req = 1'b1;
    send_alternating_polygon(24);
    wait_for_results();
  endtask

  // One long polygon whose emitted count runs past the saturation limit.
  task automatic test_count_saturation();
    set_plane('0, '0, 32'sd65536, '0);
    send_alternating_polygon(SAT_VERTICES);
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_NORMAL_X;
    cfg_wdata_i           = '0;
    vertex_ch.valid       = 1'b0;
    vertex_ch.vertex_x    = '0;
    vertex_ch.vertex_y    = '0;
    vertex_ch.vertex_z    = '0;
    vertex_ch.last_vertex = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_plane();
    test_single_vertex();
    test_coordinate_extremes();
    test_random_polygons();
    test_output_stall();
    test_count_saturation();

    if (mismatch_n == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: ready with random gaps, plus one long hold when requested.
  // Each iteration lowers ready for its gap, if any, then raises it until a transaction completes.
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned gap;
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold_req) begin
        gap = HOLD_CYCLES;
        sink_hold_req = 1'b0;
      end else begin
        gap = idle_len(sink_idle_on);
      end
      if (gap != 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      // Ready is high at every edge of this wait, so the first edge with valid
      // high completes a transaction.
      do @(posedge clk_i); while (!result_ch.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each result transaction is compared with the oldest prediction.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_check
    clip_out_t got, want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got = '{x: result_ch.out_x, y: result_ch.out_y, z: result_ch.out_z,
              is_end: result_ch.is_end, count: result_ch.out_count};
      if (pending_clip_q.size() == 0) begin
        mismatch_n++;
        if (mismatch_n <= MAX_REPORTS) begin
          $display("%0t: result with nothing predicted: x=%0d y=%0d z=%0d end=%0b count=%0d",
                   $realtime, got.x, got.y, got.z, got.is_end, got.count);
        end
      end else begin
        want = pending_clip_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.is_end !== want.is_end || got.count !== want.count) begin
          mismatch_n++;
          if (mismatch_n <= MAX_REPORTS) begin
            $display("%0t: wrong result: expected x=%0d y=%0d z=%0d end=%0b count=%0d",
                     $realtime, want.x, want.y, want.z, want.is_end, want.count);
            $display("%0t:                 got x=%0d y=%0d z=%0d end=%0b count=%0d",
                     $realtime, got.x, got.y, got.z, got.is_end, got.count);
          end
        end
      end
    end
  end

  // Generous bound: far above the slowest correct run, even with every stall at its longest.
  initial begin : run_limit
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_vertex_if.sv
hw/rtl/ppc_result_if.sv
hw/rtl/ppc_mac.sv
hw/rtl/ppc_div.sv
hw/rtl/polygon_plane_clipper_top.sv
tb/polygon_plane_clipper_top_test.sv
